[rtl/fd_violation_pair_counter_core_assert.svh]
// Assertion macros for the violation pair counter.
// Depends on nothing; taken in by the top level with an include.
`ifndef FD_VIOLATION_PAIR_COUNTER_CORE_ASSERT_SVH
`define FD_VIOLATION_PAIR_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define FVPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define FVPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fvpc_pkg.sv]
// Shared types and constants of the violation pair counter.
// Used by the output queue and the top level; depends on nothing.
`default_nettype none

package fvpc_pkg;

    localparam int ROW_AW   = 12;
    localparam int VAL_AW   = 12;
    localparam int ROWS     = 1 << ROW_AW;
    localparam int VALUES   = 1 << VAL_AW;
    localparam int CNT_W    = 13;
    localparam int TAG_W    = 12;
    localparam int SUM_W    = 23;

    localparam logic [CNT_W-1:0] COUNT_MAX   = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [TAG_W-1:0] CLUSTER_MAX = {TAG_W{1'b1}};
    localparam logic [TAG_W-1:0] CLUSTER_ONE = TAG_W'(1);

    localparam int IN_TDATA_W  = ((ROW_AW + VAL_AW + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * SUM_W + 7) / 8) * 8;
    localparam int KIND_W      = 2;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_ROW   = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    // One word of the count memory: generation tag above the count.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] count;
    } t_count_entry;

    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic [SUM_W-1:0] cluster;
    } t_result;

    // Control carried alongside an item through the pipeline.
    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic             last;
        logic [TAG_W-1:0] tag;
    } t_stage_ctl;

endpackage

`default_nettype wire

[rtl/fd_violation_pair_counter_core.sv]
// Top level of the functional dependency violation pair counter.
// Depends on fvpc_pkg, fvpc_out_fifo and the assertion macro header.
//
// Usage. Items arrive on the s_axis channel. tuser carries the kind: a load
// writes value_id into the probe table at position, a row streams one row of
// the current left-hand cluster, a clear zeroes the running total. tlast on a
// row closes the cluster. Each closing row yields one transfer on m_axis
// carrying the cluster's violating pair count and the running total.
// The cfg channel writes the singleton value id; it is always ready and
// should only be written while the block is idle.
// Latency: a closing row is accepted at edge N and its result is presented
// from the cycle after edge N+3. Throughput is one item per cycle: the probe
// memory read, the count memory read-modify-write and the total update each
// take one pipeline stage, and a count entry written by one row is forwarded
// to a directly following row with the same value id.
// Reset starts a clearing pass over the 4096-entry count memory, taking 4096
// cycles during which s_axis_tready is low. The same pass runs again after
// every 4095th cluster, once the pipeline has drained, when the generation
// tags run out. A stalled receiver is absorbed by an eight-entry result queue;
// s_axis_tready only falls when queued and in-flight results would fill it.
`default_nettype none

`include "fd_violation_pair_counter_core_assert.svh"

module fd_violation_pair_counter_core
    import fvpc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Configuration write channel.
    input  wire logic                   i_cfg_valid,
    output      logic                   o_cfg_ready,
    input  wire logic [VAL_AW-1:0]      i_cfg_data,     // singleton_value
    // Input stream.
    input  wire logic                   s_axis_tvalid,
    output      logic                   s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // position, value_id
    input  wire logic [KIND_W-1:0]      s_axis_tuser,   // kind
    input  wire logic                   s_axis_tlast,   // last_in_cluster
    // Result stream.
    output      logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output      logic [OUT_TDATA_W-1:0] m_axis_tdata    // cluster_violations,
                                                        // total_violations
);

    // ------------------------------------------------------------------
    // Input decode and front-end state.
    // ------------------------------------------------------------------
    logic              in_fire;
    t_kind             in_kind;
    logic [ROW_AW-1:0] in_pos;
    logic [VAL_AW-1:0] in_vid;
    logic              in_close;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign in_kind  = t_kind'(s_axis_tuser);
    assign in_pos   = s_axis_tdata[ROW_AW-1:0];
    assign in_vid   = s_axis_tdata[ROW_AW+VAL_AW-1:ROW_AW];
    assign in_close = (in_kind == KIND_ROW) && s_axis_tlast;

    logic [VAL_AW-1:0] r_singleton;
    logic [TAG_W-1:0]  r_cluster_num;
    logic              r_wrap_pend;
    logic              r_clr_active;
    logic [VAL_AW-1:0] r_clr_idx;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_singleton <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_singleton <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Probe memory: written by loads, read by rows at the accepting edge.
    // ------------------------------------------------------------------
    logic [VAL_AW-1:0] r_probe_mem [0:ROWS-1];
    logic [VAL_AW-1:0] r_probe_q;

    always_ff @(posedge i_clk) begin
        if (in_fire && (in_kind == KIND_LOAD)) begin
            r_probe_mem[in_pos] <= in_vid;
        end
        r_probe_q <= r_probe_mem[in_pos];
    end

    // ------------------------------------------------------------------
    // Pipeline control registers.
    // ------------------------------------------------------------------
    t_stage_ctl        r_s1;
    t_stage_ctl        r_s2;
    logic              r_s2_agrees;
    logic [VAL_AW-1:0] r_s2_vid;

    logic              r_s3_push;
    logic              r_s3_clear;
    logic [SUM_W-1:0]  r_s3_csum;

    logic              s1_res;
    logic              s2_res;
    logic              s1_agrees;

    assign s1_res    = r_s1.valid && (r_s1.kind == KIND_ROW) && r_s1.last;
    assign s2_res    = r_s2.valid && (r_s2.kind == KIND_ROW) && r_s2.last;
    assign s1_agrees = (r_probe_q != r_singleton);

    // Space check: queued results plus those still in flight must fit.
    logic [FIFO_CW-1:0] fifo_count;
    logic [FIFO_CW:0]   pending;

    assign pending = {1'b0, fifo_count} + (FIFO_CW+1)'(s1_res) + (FIFO_CW+1)'(s2_res)
                   + (FIFO_CW+1)'(r_s3_push);
    assign s_axis_tready = !r_clr_active && !r_wrap_pend
                         && (pending < (FIFO_CW+1)'(FIFO_DEPTH));

    // ------------------------------------------------------------------
    // Count memory with generation tags; read in stage 1, written in
    // stage 2 or by the clearing pass.
    // ------------------------------------------------------------------
    t_count_entry      r_cnt_mem [0:VALUES-1];
    t_count_entry      r_cnt_q;
    logic              cnt_we;
    logic [VAL_AW-1:0] cnt_waddr;
    t_count_entry      cnt_wdata;

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_q <= r_cnt_mem[r_probe_q];
    end

    // Forwarding register for a write made at the same edge as the read.
    logic              r_fw_valid;
    logic [VAL_AW-1:0] r_fw_addr;
    t_count_entry      r_fw_data;

    // Stage 2 read-modify-write.
    t_count_entry      s2_entry;
    logic [CNT_W-1:0]  s2_same;
    logic [CNT_W-1:0]  s2_new_cnt;
    logic              s2_row;
    logic              s2_wr;
    logic [CNT_W-1:0]  s2_diff;
    logic [SUM_W:0]    s2_sum_wide;
    logic [SUM_W-1:0]  s2_csum;

    logic [CNT_W-1:0]  r_rows;
    logic [SUM_W-1:0]  r_csum;

    always_comb begin
        s2_entry = (r_fw_valid && (r_fw_addr == r_s2_vid)) ? r_fw_data : r_cnt_q;
        s2_row   = r_s2.valid && (r_s2.kind == KIND_ROW);
        s2_wr    = s2_row && r_s2_agrees;
        if (r_s2_agrees && (s2_entry.tag == r_s2.tag)) begin
            s2_same = s2_entry.count;
        end else begin
            s2_same = '0;
        end
        s2_new_cnt  = (s2_same == COUNT_MAX) ? COUNT_MAX : s2_same + CNT_W'(1);
        // Earlier rows of the cluster minus earlier rows sharing the value.
        s2_diff     = r_rows - ((s2_same <= r_rows) ? s2_same : r_rows);
        s2_sum_wide = {1'b0, r_csum} + (SUM_W+1)'(s2_diff);
        s2_csum     = s2_sum_wide[SUM_W] ? SUM_MAX : s2_sum_wide[SUM_W-1:0];

        if (r_clr_active) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_clr_idx;
            cnt_wdata = '0;
        end else begin
            cnt_we    = s2_wr;
            cnt_waddr = r_s2_vid;
            cnt_wdata = '{tag: r_s2.tag, count: s2_new_cnt};
        end
    end

    // Stage 3 total update.
    logic [SUM_W:0]   s3_tot_wide;
    logic [SUM_W-1:0] s3_total;
    logic [SUM_W-1:0] r_total;
    t_result          s3_result;

    always_comb begin
        s3_tot_wide = {1'b0, r_total} + {1'b0, r_s3_csum};
        s3_total    = s3_tot_wide[SUM_W] ? SUM_MAX : s3_tot_wide[SUM_W-1:0];
        s3_result   = '{total: s3_total, cluster: r_s3_csum};
    end

    // ------------------------------------------------------------------
    // Sequential state.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_num <= CLUSTER_ONE;
            r_wrap_pend   <= 1'b0;
            r_clr_active  <= 1'b1;
            r_clr_idx     <= '0;
            r_s1          <= '0;
            r_s2          <= '0;
            r_s3_push     <= 1'b0;
            r_s3_clear    <= 1'b0;
            r_fw_valid    <= 1'b0;
            r_rows        <= '0;
            r_csum        <= '0;
            r_total       <= '0;
        end else begin
            // Front end: tag each row with its cluster generation.
            r_s1.valid <= in_fire;
            r_s1.kind  <= in_kind;
            r_s1.last  <= s_axis_tlast;
            r_s1.tag   <= r_cluster_num;
            if (in_fire && in_close) begin
                if (r_cluster_num == CLUSTER_MAX) begin
                    r_cluster_num <= CLUSTER_ONE;
                    r_wrap_pend   <= 1'b1;
                end else begin
                    r_cluster_num <= r_cluster_num + TAG_W'(1);
                end
            end

            // Clearing pass, started once nothing in flight touches counts.
            if (r_clr_active) begin
                r_clr_idx <= r_clr_idx + VAL_AW'(1);
                if (r_clr_idx == {VAL_AW{1'b1}}) begin
                    r_clr_active <= 1'b0;
                end
            end else if (r_wrap_pend && !r_s1.valid && !r_s2.valid) begin
                r_wrap_pend  <= 1'b0;
                r_clr_active <= 1'b1;
                r_clr_idx    <= '0;
            end

            // Stage 1 to stage 2.
            r_s2 <= r_s1;

            // Stage 2: forwarding record and cluster accumulation.
            r_fw_valid <= s2_wr;
            if (s2_row) begin
                if (r_s2.last) begin
                    r_rows <= '0;
                    r_csum <= '0;
                end else begin
                    r_rows <= (r_rows == COUNT_MAX) ? COUNT_MAX : r_rows + CNT_W'(1);
                    r_csum <= s2_csum;
                end
            end
            r_s3_push  <= s2_res;
            r_s3_clear <= r_s2.valid && (r_s2.kind == KIND_CLEAR);

            // Stage 3: running total.
            if (r_s3_clear) begin
                r_total <= '0;
            end else if (r_s3_push) begin
                r_total <= s3_total;
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge i_clk) begin
        r_s2_agrees <= s1_agrees;
        r_s2_vid    <= r_probe_q;
        r_fw_addr   <= r_s2_vid;
        r_fw_data   <= cnt_wdata;
        r_s3_csum   <= s2_csum;
    end

    // ------------------------------------------------------------------
    // Result queue and output packing.
    // ------------------------------------------------------------------
    t_result out_data;

    fvpc_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s3_push),
        .i_push_data (s3_result),
        .i_pop       (m_axis_tready),
        .o_valid     (m_axis_tvalid),
        .o_data      (out_data),
        .o_count     (fifo_count)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - 2 * SUM_W){1'b0}}, out_data.total,
                           out_data.cluster};

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `FVPC_ASSERT_NOW(a_clear_owns_port, i_clk, i_rst_n, r_clr_active, !r_s2.valid && !r_s1.valid, "clearing pass overlaps a counting row")
    `FVPC_ASSERT_NOW(a_queue_no_overflow, i_clk, i_rst_n, r_s3_push, (fifo_count < FIFO_CW'(FIFO_DEPTH)) || m_axis_tready, "result queue overflow")
    `FVPC_ASSERT_NEXT(a_wrap_blocks_input, i_clk, i_rst_n, in_fire && in_close && (r_cluster_num == CLUSTER_MAX), !s_axis_tready, "input accepted after tag wrap")

endmodule

`default_nettype wire

[rtl/fvpc_out_fifo.sv]
// Small result queue between the counting pipeline and the output channel.
// Depends on fvpc_pkg for the result type and the queue depth.
`default_nettype none

module fvpc_out_fifo
    import fvpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire t_result            i_push_data,
    input  wire logic               i_pop,
    output      logic               o_valid,
    output      t_result            o_data,
    output      logic [FIFO_CW-1:0] o_count
);

    t_result              r_slot [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count;
    logic                 pop_ok;

    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign o_count = r_count;
    assign pop_ok  = o_valid && i_pop;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (i_push && !pop_ok) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (!i_push && pop_ok) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

endmodule

`default_nettype wire
